FILE: src/kf_pkg.sv
// Shared types and constants for the H.264 keyframe detector.
// No dependencies; kf_golomb and the top level import this package.
`timescale 1ns / 1ps

package kf_pkg;

  localparam logic [31:0] START_MASK   = 32'hffff_ff00;
  localparam logic [31:0] SYNC_PATTERN = 32'h0000_0100;
  localparam logic [31:0] WINDOW_IDLE  = 32'hffff_ffff;
  localparam logic [4:0]  NAL_MASK     = 5'h1f;
  localparam logic [4:0]  NAL_IDR      = 5'h05;
  localparam logic [4:0]  NAL_SLICE    = 5'h01;

  // slice kind codes that mark an I or SI slice
  localparam logic [7:0] SLICE_P_I  = 8'd2;
  localparam logic [7:0] SLICE_P_SI = 8'd4;
  localparam logic [7:0] SLICE_A_I  = 8'd7;
  localparam logic [7:0] SLICE_A_SI = 8'd9;

  // Exp-Golomb parser state
  typedef struct packed {
    logic       value_index;
    logic [5:0] zero_count;
    logic [5:0] suffix_left;
    logic [7:0] code_value;
    logic       in_prefix;
  } gol_state_t;

  // parser outcome for one byte
  typedef struct packed {
    logic decided;
    logic is_key;
  } gol_result_t;

  function automatic gol_state_t gol_init();
    gol_state_t s;
    s.value_index = 1'b0;
    s.zero_count  = 6'd0;
    s.suffix_left = 6'd0;
    s.code_value  = 8'd0;
    s.in_prefix   = 1'b1;
    return s;
  endfunction

  function automatic logic is_intra_kind(input logic [7:0] t);
    return (t == SLICE_P_I) || (t == SLICE_P_SI) || (t == SLICE_A_I) || (t == SLICE_A_SI);
  endfunction

endpackage

FILE: src/kf_byte_if.sv
// Stream byte channel: valid/ready handshake with one byte and a packet end mark.
// Depends on nothing.
`timescale 1ns / 1ps

interface kf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_packet;

  modport source (output valid, output data_byte, output last_in_packet, input ready);
  modport sink (input valid, input data_byte, input last_in_packet, output ready);
endinterface

FILE: src/kf_result_if.sv
// Result channel: valid/ready handshake with the keyframe decision.
// Depends on nothing.
`timescale 1ns / 1ps

interface kf_result_if;
  logic valid;
  logic ready;
  logic is_keyframe;
  logic decided;

  modport source (output valid, output is_keyframe, output decided, input ready);
  modport sink (input valid, input is_keyframe, input decided, output ready);
endinterface

FILE: src/kf_golomb.sv
// Eight-bit Exp-Golomb step: reads one byte MSB first, skips the first macroblock
// address, then checks the slice kind. Combinational. Depends on kf_pkg.
`timescale 1ns / 1ps

module kf_golomb
  import kf_pkg::*;
(
  input  gol_state_t  state,
  input  logic [7:0]  data_byte,
  output gol_state_t  state_next,
  output gol_result_t result
);

  always_comb begin
    gol_state_t s;
    logic       done;
    logic       key;
    logic       fin;
    logic [7:0] val;
    s    = state;
    done = 1'b0;
    key  = 1'b0;
    fin  = 1'b0;
    val  = 8'd0;
    for (int i = 7; i >= 0; i--) begin
      fin = 1'b0;
      if (!done) begin
        if (s.in_prefix) begin
          if (!data_byte[i]) begin
            s.zero_count = s.zero_count + 6'd1;
            // 32 leading zeros: give up, not a keyframe
            if (s.zero_count[5]) begin
              done = 1'b1;
              key  = 1'b0;
            end
          end else begin
            s.code_value = 8'd1;
            if (s.zero_count == 6'd0) begin
              fin = 1'b1;
            end else begin
              s.in_prefix   = 1'b0;
              s.suffix_left = s.zero_count;
            end
          end
        end else begin
          s.code_value  = {s.code_value[6:0], data_byte[i]};
          s.suffix_left = s.suffix_left - 6'd1;
          if (s.suffix_left == 6'd0) begin
            fin = 1'b1;
          end
        end
        if (fin) begin
          val = s.code_value - 8'd1;
          if (!s.value_index) begin
            s             = gol_init();
            s.value_index = 1'b1;
          end else begin
            done = 1'b1;
            key  = is_intra_kind(val);
          end
        end
      end
    end
    state_next     = s;
    result.decided = done;
    result.is_key  = key;
  end

endmodule

FILE: src/h264_keyframe_detector_core.sv
// H.264 Annex B keyframe detector, top level.
// Depends on kf_pkg, kf_byte_if, kf_result_if and kf_golomb.
`timescale 1ns / 1ps

// Takes one stream byte per cycle and answers once per packet. A 32-bit window
// that persists across packets finds 00 00 01 start codes; an IDR NAL decides
// keyframe at once, a non-IDR slice NAL has its slice kind parsed bit by bit
// from the following bytes, eight bits per byte, and other NAL types are passed
// over. After a decision the rest of the packet is ignored. A packet with no
// decision answers "undecided" at its last byte; a packet that ends mid-parse
// answers "not key, decided". Bytes are taken back to back while input is not
// stalled; the answer shows on the result port the cycle after the byte that
// caused it when the output register is free. The longest path is the
// eight-bit Exp-Golomb step. A two-deep output stage lets input flow on while
// one answer waits to be taken; input stalls only while two answers wait.
module h264_keyframe_detector_core
  import kf_pkg::*;
(
  input logic          clk,
  input logic          rst,
  kf_byte_if.sink      byte_in,
  kf_result_if.source  result_out
);

  typedef enum logic [1:0] {
    SCAN  = 2'd0,
    PARSE = 2'd1,
    SKIP  = 2'd2
  } phase_t;

  logic [31:0] window;
  logic [31:0] window_next;
  phase_t      phase;
  phase_t      phase_next;
  gol_state_t  gol;
  gol_state_t  gol_next;
  gol_state_t  gol_step;
  gol_result_t gol_res;

  logic        res_valid;
  logic        res_key;
  logic        res_dec;
  logic [31:0] window_shift;

  logic        o_valid;
  logic        o_key;
  logic        o_dec;
  logic        s_valid;
  logic        s_key;
  logic        s_dec;

  logic        in_fire;
  logic        out_fire;

  kf_golomb u_golomb (
    .state      (gol),
    .data_byte  (byte_in.data_byte),
    .state_next (gol_step),
    .result     (gol_res)
  );

  assign in_fire  = byte_in.valid && byte_in.ready;
  assign out_fire = o_valid && result_out.ready;

  assign byte_in.ready          = !s_valid;
  assign result_out.valid       = o_valid;
  assign result_out.is_keyframe = o_key;
  assign result_out.decided     = o_dec;

  assign window_shift = {window[23:0], byte_in.data_byte};

  always_comb begin
    window_next = window;
    phase_next  = phase;
    gol_next    = gol;
    res_key     = 1'b0;
    res_dec     = 1'b0;
    case (phase)
      SCAN: begin
        window_next = window_shift;
        if ((window_shift & START_MASK) == SYNC_PATTERN) begin
          if ((window_shift[4:0] & NAL_MASK) == NAL_IDR) begin
            res_dec = 1'b1;
            res_key = 1'b1;
          end else if ((window_shift[4:0] & NAL_MASK) == NAL_SLICE) begin
            phase_next = PARSE;
            gol_next   = gol_init();
          end
        end
      end
      PARSE: begin
        gol_next = gol_step;
        res_dec  = gol_res.decided;
        res_key  = gol_res.is_key;
      end
      default: begin
        // skipping: ignore bytes until the packet ends
      end
    endcase
    // packet ends inside a slice header: decide not key
    if (!res_dec && byte_in.last_in_packet && phase_next == PARSE) begin
      res_dec = 1'b1;
      res_key = 1'b0;
    end
    res_valid = res_dec || (byte_in.last_in_packet && phase_next == SCAN);
    if (res_dec) begin
      window_next = WINDOW_IDLE;
      phase_next  = SKIP;
    end
    if (byte_in.last_in_packet) begin
      phase_next = SCAN;
      gol_next   = gol_init();
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window  <= WINDOW_IDLE;
      phase   <= SCAN;
      gol     <= gol_init();
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        window <= window_next;
        phase  <= phase_next;
        gol    <= gol_next;
      end
      // output stage: main register plus skid
      if (s_valid) begin
        if (out_fire) begin
          o_key   <= s_key;
          o_dec   <= s_dec;
          s_valid <= 1'b0;
        end
      end else if (in_fire && res_valid) begin
        if (!o_valid || out_fire) begin
          o_valid <= 1'b1;
          o_key   <= res_key;
          o_dec   <= res_dec;
        end else begin
          s_valid <= 1'b1;
          s_key   <= res_key;
          s_dec   <= res_dec;
        end
      end else if (out_fire) begin
        o_valid <= 1'b0;
      end
    end
  end

endmodule
